/* rtl/fps_pkg.sv */
// Package for the frequency priority scheduler.
// Holds operation codes, field widths and the controller/datapath command and status types.
// No dependencies.
package fps_pkg;

    // Field widths of one input transaction and one result transaction.
    localparam int OP_W      = 2;
    localparam int PROC_ID_W = 4;
    localparam int COUNT_W   = 8;
    localparam int CHOSEN_W  = 4;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_SET    = 2'd2;
    localparam logic [OP_W-1:0] OP_GET    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // Take the input transaction and read the addressed entry.
        logic scan_rd;  // Read the next entry of the scan.
        logic modify;   // Write back the updated counts of the latched id.
        logic finish;   // Write back the chosen id and load the result register.
    } fps_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_get;     // Incoming transaction is a get-next.
        logic in_id_ok;   // Incoming id addresses a stored entry.
        logic scan_last;  // The scan reads its final entry in this cycle.
        logic out_busy;   // The result register holds a result that is not taken.
    } fps_status_t;

endpackage

/* rtl/frequency_priority_scheduler_top.sv */
// Frequency priority scheduler: add, remove and set-count read one id's entry, then write back its updated counts.
// Get-next scans the count stores one entry per cycle, then passes a drain state and waits in the finish
// state until the output register holds no untaken result, loads the result there and frees the input.
// A new transaction is taken while a finished result still waits in the output register.
// Reset (rst_n, asynchronous, active low) clears all counts through per-entry valid bits.
// Depends on fps_pkg, fps_ctrl and fps_datapath.
module frequency_priority_scheduler_top
    import fps_pkg::*;
#(
    parameter int NUM_IDS      = 16,
    parameter int PENDING_BITS = 8,
    parameter int HISTORY_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [3:0] proc_id, [11:4] count_value, [15:12] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [3:0] chosen_id, [7:4] zero
    output logic        m_axis_tuser    // [0] found
);

    fps_cmd_t            cmd;
    fps_status_t         status;
    logic [CHOSEN_W-1:0] chosen_id;

    // Controller.
    fps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    fps_datapath #(
        .NUM_IDS      (NUM_IDS),
        .PENDING_BITS (PENDING_BITS),
        .HISTORY_BITS (HISTORY_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_operation   (s_axis_tuser),
        .in_proc_id     (s_axis_tdata[3:0]),
        .in_count_value (s_axis_tdata[11:4]),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_found      (m_axis_tuser),
        .out_chosen_id  (chosen_id)
    );

    assign m_axis_tdata = {4'b0000, chosen_id};

endmodule

/* rtl/fps_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/fps_ctrl.sv */
// Controller state machine of the frequency priority scheduler.
// Depends on fps_pkg for the command and status types.
module fps_ctrl
    import fps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  fps_status_t status,
    output fps_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_ready && in_valid;

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.load    = accept;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (status.in_get)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (status.in_id_ok)
                    begin
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                cmd.modify = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/fps_datapath.sv */
// Datapath of the frequency priority scheduler: count stores, update arithmetic,
// the one-entry-per-cycle priority scan and the result register.
// Depends on fps_pkg and fps_ram.
module fps_datapath
    import fps_pkg::*;
#(
    parameter int NUM_IDS      = 16,
    parameter int PENDING_BITS = 8,
    parameter int HISTORY_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [OP_W-1:0]      in_operation,
    input  logic [PROC_ID_W-1:0] in_proc_id,
    input  logic [COUNT_W-1:0]   in_count_value,
    input  fps_cmd_t             cmd,
    output fps_status_t          status,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 out_found,
    output logic [CHOSEN_W-1:0]  out_chosen_id
);

    localparam int IDX_W = $clog2(NUM_IDS);
    localparam int SUM_W = ((HISTORY_BITS > PENDING_BITS) ? HISTORY_BITS : PENDING_BITS) + 1;
    localparam logic [PENDING_BITS-1:0] PEND_MAX = {PENDING_BITS{1'b1}};
    localparam logic [HISTORY_BITS-1:0] HIST_MAX = {HISTORY_BITS{1'b1}};

    // Latched transaction.
    logic [OP_W-1:0]    op_reg;
    logic [IDX_W-1:0]   id_reg;
    logic [COUNT_W-1:0] count_reg;

    // Scan state.
    logic [IDX_W-1:0]        scan_idx_reg;
    logic                    cmp_en_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic                    best_valid_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic [HISTORY_BITS-1:0] best_hist_reg;
    logic [PENDING_BITS-1:0] best_pend_reg;

    // Entry valid bits: an entry never written reads as zero.
    logic [NUM_IDS-1:0] valid_reg;
    logic               rd_valid_reg;

    // Result register.
    logic                out_valid_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    chosen_reg;

    // Memory ports.
    logic [IDX_W-1:0]        raddr;
    logic [IDX_W-1:0]        waddr;
    logic                    we;
    logic [PENDING_BITS-1:0] pend_wdata;
    logic [HISTORY_BITS-1:0] hist_wdata;
    logic [PENDING_BITS-1:0] pend_rdata;
    logic [HISTORY_BITS-1:0] hist_rdata;
    logic [PENDING_BITS-1:0] pend_q;
    logic [HISTORY_BITS-1:0] hist_q;

    // Update arithmetic.
    logic [IDX_W+PROC_ID_W-1:0]    pid_ext;
    logic [PENDING_BITS+COUNT_W-1:0] cv_ext;
    logic [PENDING_BITS-1:0]       new_pend;
    logic [SUM_W-1:0]              hist_sum;
    logic [SUM_W-1:0]              hist_diff;
    logic [PENDING_BITS-1:0]       mod_pend;
    logic [HISTORY_BITS-1:0]       mod_hist;
    logic                          take_entry;
    logic [IDX_W+CHOSEN_W-1:0]     chosen_ext;

    // Incoming id as a store index and its range check.
    assign pid_ext          = {{IDX_W{1'b0}}, in_proc_id};
    assign status.in_id_ok  = (32'(pid_ext) < NUM_IDS);
    assign status.in_get    = (in_operation == OP_GET);
    assign status.scan_last = (scan_idx_reg == IDX_W'(NUM_IDS - 1));
    assign status.out_busy  = out_valid_reg && !out_ready;

    // Count stores.
    assign raddr = cmd.scan_rd ? scan_idx_reg : pid_ext[IDX_W-1:0];

    fps_ram #(
        .WIDTH (PENDING_BITS),
        .DEPTH (NUM_IDS)
    ) u_pend_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (pend_wdata),
        .raddr (raddr),
        .rdata (pend_rdata)
    );

    fps_ram #(
        .WIDTH (HISTORY_BITS),
        .DEPTH (NUM_IDS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (hist_wdata),
        .raddr (raddr),
        .rdata (hist_rdata)
    );

    assign pend_q = rd_valid_reg ? pend_rdata : '0;
    assign hist_q = rd_valid_reg ? hist_rdata : '0;

    // Set-count: saturate the new value, then move history by the difference.
    assign cv_ext    = {{PENDING_BITS{1'b0}}, count_reg};
    assign new_pend  = (cv_ext > {{COUNT_W{1'b0}}, PEND_MAX}) ? PEND_MAX
                                                              : cv_ext[PENDING_BITS-1:0];
    assign hist_sum  = SUM_W'(hist_q) + SUM_W'(new_pend);
    assign hist_diff = hist_sum - SUM_W'(pend_q);

    // New counts of the latched id.
    always_comb
    begin
        mod_pend = pend_q;
        mod_hist = hist_q;
        case (op_reg)
            OP_ADD:
            begin
                mod_pend = (pend_q == PEND_MAX) ? PEND_MAX : pend_q + PENDING_BITS'(1);
                mod_hist = (hist_q == HIST_MAX) ? HIST_MAX : hist_q + HISTORY_BITS'(1);
            end
            OP_REMOVE:
            begin
                if (pend_q != '0)
                begin
                    mod_pend = pend_q - PENDING_BITS'(1);
                    mod_hist = (hist_q == '0) ? '0 : hist_q - HISTORY_BITS'(1);
                end
            end
            OP_SET:
            begin
                mod_pend = new_pend;
                if (hist_sum < SUM_W'(pend_q))
                begin
                    mod_hist = '0;
                end
                else if (hist_diff > SUM_W'(HIST_MAX))
                begin
                    mod_hist = HIST_MAX;
                end
                else
                begin
                    mod_hist = hist_diff[HISTORY_BITS-1:0];
                end
            end
            default:
            begin
                mod_pend = pend_q;
                mod_hist = hist_q;
            end
        endcase
    end

    // Write port: modify writes the latched id, finish writes the chosen id.
    assign we         = cmd.modify || (cmd.finish && best_valid_reg);
    assign waddr      = cmd.modify ? id_reg : best_idx_reg;
    assign pend_wdata = cmd.modify ? mod_pend : best_pend_reg - PENDING_BITS'(1);
    assign hist_wdata = cmd.modify ? mod_hist : best_hist_reg;

    // Valid bits and the valid flag of the entry being read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[raddr];
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    // Latch the transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_operation;
            id_reg    <= pid_ext[IDX_W-1:0];
            count_reg <= in_count_value;
        end
    end

    // An entry wins when it is pending and strictly beats the best so far.
    assign take_entry = cmp_en_reg && (pend_q != '0)
                        && (!best_valid_reg || (hist_q > best_hist_reg));

    // Scan counter and best-so-far tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg   <= '0;
            cmp_en_reg     <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_en_reg <= cmd.scan_rd;
            if (cmd.load)
            begin
                scan_idx_reg   <= '0;
                best_valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                end
                if (take_entry)
                begin
                    best_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Best entry payload and the index of the entry under compare.
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_idx_reg;
        if (take_entry)
        begin
            best_idx_reg  <= cmp_idx_reg;
            best_hist_reg <= hist_q;
            best_pend_reg <= pend_q;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            chosen_reg    <= '0;
        end
        else
        begin
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                found_reg     <= best_valid_reg;
                chosen_reg    <= best_valid_reg ? best_idx_reg : '0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign chosen_ext    = {{CHOSEN_W{1'b0}}, chosen_reg};
    assign out_valid     = out_valid_reg;
    assign out_found     = found_reg;
    assign out_chosen_id = chosen_ext[CHOSEN_W-1:0];

endmodule
